// ===== rtl/core/bitblt_pkg.sv =====
// ----------------------------------------------------------------------------
// Bit-block transfer word datapath package
// Word type, position codes, register indexes and raster-op codes.
// ----------------------------------------------------------------------------
package bitblt_pkg;

    localparam int WORD_BITS = 32;
    localparam int SKEW_BITS = $clog2(WORD_BITS);

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [SKEW_BITS-1:0] skew_t;
    typedef logic [1:0]           position_t;
    typedef logic [3:0]           rop_t;
    typedef logic [2:0]           cfg_index_t;

    localparam word_t WORD_ONES = '1;

    // Position of a word within a row.
    localparam position_t POS_PRIME  = 2'd0;
    localparam position_t POS_FIRST  = 2'd1;
    localparam position_t POS_MIDDLE = 2'd2;
    localparam position_t POS_LAST   = 2'd3;

    // Configuration register indexes.
    localparam cfg_index_t CFG_ROP        = 3'd0;
    localparam cfg_index_t CFG_SKEW       = 3'd1;
    localparam cfg_index_t CFG_BACKWARD   = 3'd2;
    localparam cfg_index_t CFG_FIRST_MASK = 3'd3;
    localparam cfg_index_t CFG_LAST_MASK  = 3'd4;

    // Raster operations on source s, destination d and texture t.
    localparam rop_t ROP_ZEROS       = 4'd0;
    localparam rop_t ROP_S_AND_D     = 4'd1;
    localparam rop_t ROP_S_AND_ND    = 4'd2;
    localparam rop_t ROP_S           = 4'd3;
    localparam rop_t ROP_NS_AND_D    = 4'd4;
    localparam rop_t ROP_D           = 4'd5;
    localparam rop_t ROP_S_XOR_D     = 4'd6;
    localparam rop_t ROP_S_OR_D      = 4'd7;
    localparam rop_t ROP_NS_AND_ND   = 4'd8;
    localparam rop_t ROP_NS_XOR_D    = 4'd9;
    localparam rop_t ROP_ND          = 4'd10;
    localparam rop_t ROP_S_OR_ND     = 4'd11;
    localparam rop_t ROP_NS          = 4'd12;
    localparam rop_t ROP_NS_OR_D     = 4'd13;
    localparam rop_t ROP_NS_OR_ND    = 4'd14;
    localparam rop_t ROP_ONES        = 4'd15;

    localparam rop_t ROP_RESET = ROP_D;

endpackage

// ===== rtl/core/bitblt_word_raster_op.sv =====
// ----------------------------------------------------------------------------
// Bit-block transfer word raster-op datapath
// Skew merge, rotation, raster operation and edge masking of one word.
// ----------------------------------------------------------------------------
// The block takes one word per cycle while the output is not stalled and
// returns one result word per non-prime word through its output register.
// Each accepted word lands in an input register together with a snapshot of
// the carried previous source word and the primed flag; the merge, the barrel
// rotation, the raster operation and the edge blend are then worked out in
// one pass of logic and caught in the output register. The carried source
// word is a single register updated at acceptance, so back-to-back words of a
// row flow at one per cycle. A prime word only loads the carried source and
// produces no result. Configuration registers are written through a separate
// port that is always ready and must only be written while the block is idle.
module bitblt_word_raster_op
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  bitblt_pkg::word_t      src_word,
    input  bitblt_pkg::word_t      dst_word,
    input  bitblt_pkg::word_t      texture_word,
    input  bitblt_pkg::position_t  position,

    output logic                   out_valid,
    input  logic                   out_ready,
    output bitblt_pkg::word_t      new_word,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  bitblt_pkg::cfg_index_t cfg_index,
    input  bitblt_pkg::word_t      cfg_data
);
    import bitblt_pkg::*;

    // Configuration registers.
    rop_t  rop_reg;
    skew_t skew_reg;
    logic  backward_reg;
    word_t first_mask_reg;
    word_t last_mask_reg;

    // Carried state between words of a row.
    word_t prev_source_reg, prev_source_next;
    logic  primed_reg, primed_next;

    // Input stage.
    logic      s1_valid_reg, s1_valid_next;
    word_t     s1_src_reg, s1_dst_reg, s1_tex_reg, s1_prev_reg;
    position_t s1_pos_reg;
    logic      s1_primed_reg;

    // Output stage.
    logic  out_valid_reg, out_valid_next;
    word_t out_word_reg;

    logic in_fire;
    logic s1_advance;
    logic cfg_fire;

    // Datapath signals of the single pass.
    word_t merge_mask;
    word_t merged;
    word_t rotated;
    word_t src_term;
    word_t rop_result;
    word_t result;
    logic [2*WORD_BITS-1:0] rot_wide;

    assign cfg_ready  = 1'b1;
    assign cfg_fire   = cfg_valid && cfg_ready;

    // The output register drains when it is empty or being taken; the input
    // stage moves forward whenever the output register can take its word.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_fire    = in_valid && in_ready;

    assign out_valid  = out_valid_reg;
    assign new_word   = out_word_reg;

    // Configuration writes; indexes beyond the register list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rop_reg        <= ROP_RESET;
            skew_reg       <= '0;
            backward_reg   <= 1'b0;
            first_mask_reg <= WORD_ONES;
            last_mask_reg  <= WORD_ONES;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                CFG_ROP:        rop_reg        <= cfg_data[3:0];
                CFG_SKEW:       skew_reg       <= cfg_data[SKEW_BITS-1:0];
                CFG_BACKWARD:   backward_reg   <= cfg_data[0];
                CFG_FIRST_MASK: first_mask_reg <= cfg_data;
                CFG_LAST_MASK:  last_mask_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Carried source word and primed flag follow every accepted word in
    // order: a prime word sets the flag, any other word clears it.
    always_comb
    begin
        prev_source_next = prev_source_reg;
        primed_next      = primed_reg;
        if (in_fire)
        begin
            prev_source_next = src_word;
            primed_next      = (position == POS_PRIME);
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = (position != POS_PRIME);
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_source_reg <= '0;
            primed_reg      <= 1'b0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            prev_source_reg <= prev_source_next;
            primed_reg      <= primed_next;
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Input stage payload, with a snapshot of the carried state as it stood
    // before this word.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_src_reg    <= src_word;
            s1_dst_reg    <= dst_word;
            s1_tex_reg    <= texture_word;
            s1_pos_reg    <= position;
            s1_prev_reg   <= prev_source_reg;
            s1_primed_reg <= primed_reg;
        end
    end

    // Skew merge mask: empty for a zero skew, else the low WORD_BITS minus skew
    // bits; a right-to-left walk takes the complement.
    always_comb
    begin
        merge_mask = (skew_reg == '0) ? '0 : (WORD_ONES >> skew_reg);
        if (backward_reg)
        begin
            merge_mask = ~merge_mask;
        end
    end

    // An unprimed first word has nothing to merge with, so the bits that
    // would come from the previous word are left clear.
    always_comb
    begin
        if ((s1_pos_reg == POS_FIRST) && !s1_primed_reg)
        begin
            merged = s1_src_reg & ~merge_mask;
        end
        else
        begin
            merged = (s1_prev_reg & merge_mask) | (s1_src_reg & ~merge_mask);
        end
    end

    // Left rotation: the upper half of the doubled word shifted by the skew.
    assign rot_wide = {merged, merged} << skew_reg;
    assign rotated  = rot_wide[2*WORD_BITS-1:WORD_BITS];
    assign src_term = rotated & s1_tex_reg;

    always_comb
    begin
        case (rop_reg)
            ROP_ZEROS:     rop_result = '0;
            ROP_S_AND_D:   rop_result = src_term & s1_dst_reg;
            ROP_S_AND_ND:  rop_result = src_term & ~s1_dst_reg;
            ROP_S:         rop_result = src_term;
            ROP_NS_AND_D:  rop_result = ~src_term & s1_dst_reg;
            ROP_D:         rop_result = s1_dst_reg;
            ROP_S_XOR_D:   rop_result = src_term ^ s1_dst_reg;
            ROP_S_OR_D:    rop_result = src_term | s1_dst_reg;
            ROP_NS_AND_ND: rop_result = ~src_term & ~s1_dst_reg;
            ROP_NS_XOR_D:  rop_result = ~src_term ^ s1_dst_reg;
            ROP_ND:        rop_result = ~s1_dst_reg & s1_tex_reg;
            ROP_S_OR_ND:   rop_result = src_term | ~s1_dst_reg;
            ROP_NS:        rop_result = ~src_term;
            ROP_NS_OR_D:   rop_result = ~src_term | s1_dst_reg;
            ROP_NS_OR_ND:  rop_result = ~src_term | ~s1_dst_reg;
            ROP_ONES:      rop_result = s1_tex_reg;
            default:       rop_result = s1_tex_reg;
        endcase
    end

    // Edge words keep the old destination outside their edge mask.
    always_comb
    begin
        case (s1_pos_reg)
            POS_FIRST: result = (first_mask_reg & rop_result)
                              | (~first_mask_reg & s1_dst_reg);
            POS_LAST:  result = (last_mask_reg & rop_result)
                              | (~last_mask_reg & s1_dst_reg);
            default:   result = rop_result;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_word_reg <= result;
        end
    end

    // A prime word arms the merge for the next word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (position == POS_PRIME)) |=> primed_reg)
        else $error("prime word did not set the primed flag");

    // A result-producing word clears the flag and occupies the input stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (position != POS_PRIME)) |=> (!primed_reg && s1_valid_reg))
        else $error("result word not captured or primed flag not cleared");

    // The input side only stalls when both stages are full and blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled while the pipeline could move");

    // A word leaving the input stage shows up at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> out_valid_reg)
        else $error("word left the input stage but no result appeared");

    // The carried source word changes only on an accepted word.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(prev_source_reg))
        else $error("carried source word changed without an accepted word");

endmodule

// ===== dv/bitblt_word_checker.sv =====
// ----------------------------------------------------------------------------
// Raster-op word checker
// Watches the word, result and register channels of the raster-op datapath,
// predicts each result word and compares it with what the block returns.
// ----------------------------------------------------------------------------
module bitblt_word_checker
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    input  logic                   in_ready,
    input  bitblt_pkg::word_t      src_word,
    input  bitblt_pkg::word_t      dst_word,
    input  bitblt_pkg::word_t      texture_word,
    input  bitblt_pkg::position_t  position,

    input  logic                   out_valid,
    input  logic                   out_ready,
    input  bitblt_pkg::word_t      new_word,

    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  bitblt_pkg::cfg_index_t cfg_index,
    input  bitblt_pkg::word_t      cfg_data,

    output int                     error_count,
    output int                     pending_words
);
    timeunit 1ns;
    timeprecision 1ps;
    import bitblt_pkg::*;

    // Shadow copies of the registers and of the carried source state.
    rop_t  rop_cfg        = ROP_RESET;
    skew_t skew_cfg       = '0;
    logic  backward_cfg   = 1'b0;
    word_t first_edge     = WORD_ONES;
    word_t last_edge      = WORD_ONES;
    word_t carried_source = '0;
    logic  carried_primed = 1'b0;

    word_t expected_words[$];
    word_t oldest_word;

    // Destination word that a non-prime word should produce, given the
    // current registers and carried source.
    function automatic word_t raster_word(word_t src, word_t dst, word_t tex,
                                          position_t pos);
        word_t merge_mask;
        word_t merged;
        word_t aligned;
        word_t s;
        word_t result;

        merge_mask = (skew_cfg == '0) ? '0 : (WORD_ONES >> skew_cfg);
        if (backward_cfg)
            merge_mask = ~merge_mask;

        if (pos == POS_FIRST && !carried_primed)
            merged = src & ~merge_mask;
        else
            merged = (carried_source & merge_mask) | (src & ~merge_mask);

        if (skew_cfg == '0)
            aligned = merged;
        else
            aligned = (merged << skew_cfg) | (merged >> (WORD_BITS - skew_cfg));
        s = aligned & tex;

        case (rop_cfg)
            ROP_ZEROS:     result = '0;
            ROP_S_AND_D:   result = s & dst;
            ROP_S_AND_ND:  result = s & ~dst;
            ROP_S:         result = s;
            ROP_NS_AND_D:  result = ~s & dst;
            ROP_D:         result = dst;
            ROP_S_XOR_D:   result = s ^ dst;
            ROP_S_OR_D:    result = s | dst;
            ROP_NS_AND_ND: result = ~s & ~dst;
            ROP_NS_XOR_D:  result = ~s ^ dst;
            ROP_ND:        result = ~dst & tex;
            ROP_S_OR_ND:   result = s | ~dst;
            ROP_NS:        result = ~s;
            ROP_NS_OR_D:   result = ~s | dst;
            ROP_NS_OR_ND:  result = ~s | ~dst;
            default:       result = tex;
        endcase

        if (pos == POS_FIRST)
            result = (first_edge & result) | (~first_edge & dst);
        else if (pos == POS_LAST)
            result = (last_edge & result) | (~last_edge & dst);
        return result;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rop_cfg        = ROP_RESET;
            skew_cfg       = '0;
            backward_cfg   = 1'b0;
            first_edge     = WORD_ONES;
            last_edge      = WORD_ONES;
            carried_source = '0;
            carried_primed = 1'b0;
            expected_words.delete();
            pending_words <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("new_word: expected none, got %08h", new_word);
                    error_count++;
                end
                else
                begin
                    oldest_word = expected_words.pop_front();
                    if (new_word !== oldest_word)
                    begin
                        $error("new_word: expected %08h, got %08h", oldest_word, new_word);
                        error_count++;
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                if (position != POS_PRIME)
                    expected_words.push_back(raster_word(src_word, dst_word,
                                                         texture_word, position));
                carried_source = src_word;
                carried_primed = (position == POS_PRIME);
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ROP:        rop_cfg = cfg_data[3:0];
                    CFG_SKEW:       skew_cfg = cfg_data[SKEW_BITS-1:0];
                    CFG_BACKWARD:   backward_cfg = cfg_data[0];
                    CFG_FIRST_MASK: first_edge = cfg_data;
                    CFG_LAST_MASK:  last_edge = cfg_data;
                    default:        ;
                endcase
            end

            // Published after the edge so that every reader sees the count
            // as of the previous edge.
            pending_words <= expected_words.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Raster-op word datapath testbench
// Drives rows of words through the datapath under many register settings,
// with random sender gaps and receiver stalls; a checker beside the block
// predicts every result word and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bitblt_pkg::*;

    // Cycles without any accepted word, result or register write before the
    // run is declared hung. The slowest correct stretch is a bounded sender gap
    // or receiver stall plus the drain pause.
    localparam int QUIET_LIMIT  = 500;
    localparam int RANDOM_WORDS = 950;
    localparam int PHASE_WORDS  = 90;
    // The block answers through its input and output registers; a prime word
    // leaves nothing behind to wait for, so a short fixed pause covers it.
    localparam int DRAIN_CYCLES = 4;
    localparam int MAX_STALL    = 12;

    // Receiver behaviors.
    localparam int READY_ALWAYS = 0;
    localparam int READY_COIN   = 1;
    localparam int READY_SPARSE = 2;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;

    logic       in_valid     = 1'b0;
    logic       in_ready;
    word_t      src_word     = '0;
    word_t      dst_word     = '0;
    word_t      texture_word = '0;
    position_t  position     = POS_PRIME;

    logic       out_valid;
    logic       out_ready    = 1'b0;
    word_t      new_word;

    logic       cfg_valid    = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index    = CFG_ROP;
    word_t      cfg_data     = '0;

    int error_count;
    int pending_words;

    int   words_sent      = 0;
    int   burst_left      = 0;
    int   ready_mode      = READY_ALWAYS;
    int   ready_mode_left = 0;
    int   stall_run       = 0;
    int   quiet_cycles    = 0;
    logic grant           = 1'b1;

    bitblt_word_raster_op dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .src_word     (src_word),
        .dst_word     (dst_word),
        .texture_word (texture_word),
        .position     (position),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .new_word     (new_word),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    bitblt_word_checker word_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .src_word      (src_word),
        .dst_word      (dst_word),
        .texture_word  (texture_word),
        .position      (position),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .new_word      (new_word),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .pending_words (pending_words)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // The receiver switches between always ready, a coin toss per cycle and
    // mostly stalled. A stall is cut off once it reaches MAX_STALL so the
    // watchdog limit can be reckoned.
    always @(posedge clk)
    begin
        if (ready_mode_left == 0)
        begin
            ready_mode      = $urandom_range(READY_ALWAYS, READY_SPARSE);
            ready_mode_left = $urandom_range(32, 200);
        end
        else
        begin
            ready_mode_left--;
        end

        case (ready_mode)
            READY_ALWAYS: grant = 1'b1;
            READY_COIN:   grant = 1'($urandom_range(0, 1));
            default:      grant = ($urandom_range(0, 5) == 0);
        endcase
        if (stall_run >= MAX_STALL)
            grant = 1'b1;
        stall_run = grant ? 0 : stall_run + 1;
        out_ready <= grant;
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Mostly random words, with all-zero and all-one words mixed in so the
    // extremes show up throughout the run.
    function automatic word_t rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return WORD_ONES;
            default: return $urandom();
        endcase
    endfunction

    // Half of all rows are untextured, which means an all-ones texture word.
    function automatic word_t rand_texture();
        return ($urandom_range(0, 1) == 1) ? WORD_ONES : rand_word();
    endfunction

    function automatic word_t rand_mask();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return WORD_ONES;
            default: return $urandom();
        endcase
    endfunction

    // Zero skew and the largest skew are special enough to get half the draws.
    function automatic skew_t rand_skew();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return skew_t'($urandom_range(0, WORD_BITS - 1));
        endcase
    endfunction

    // Offers one word and returns once it is accepted. The sender works in
    // bursts: at the start of each burst it may drop valid for a random gap.
    // Valid is never lowered and raised in the same time step.
    task automatic send_word(word_t src, word_t dst, word_t tex, position_t pos);
        int gap;

        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 96)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;

        in_valid     <= 1'b1;
        src_word     <= src;
        dst_word     <= dst;
        texture_word <= tex;
        position     <= pos;
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    // A well-formed row: an optional prime word, the first word, a few
    // middle words and the last word, all sharing one texture word.
    task automatic send_row();
        int    middles;
        word_t tex;

        middles = $urandom_range(0, 6);
        tex     = rand_texture();
        if ($urandom_range(0, 1) == 1)
            send_word(rand_word(), rand_word(), tex, POS_PRIME);
        send_word(rand_word(), rand_word(), tex, POS_FIRST);
        repeat (middles) send_word(rand_word(), rand_word(), tex, POS_MIDDLE);
        send_word(rand_word(), rand_word(), tex, POS_LAST);
    endtask

    // Lets the block run dry. The first edge makes sure a word accepted at
    // the current edge already shows in the checker's pending count.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, word_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Writes every register back to back. The narrow registers get random
    // upper data bits, which the block must ignore.
    task automatic write_config(rop_t rop, skew_t skew, logic back,
                                word_t first_mask, word_t last_mask);
        word_t junk;

        junk = $urandom();
        write_reg(CFG_ROP,        {junk[WORD_BITS-1:4], rop});
        write_reg(CFG_SKEW,       {junk[WORD_BITS-1:SKEW_BITS], skew});
        write_reg(CFG_BACKWARD,   {junk[WORD_BITS-1:1], back});
        write_reg(CFG_FIRST_MASK, first_mask);
        write_reg(CFG_LAST_MASK,  last_mask);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int random_start;
        int phase_start;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: pass the destination through, no skew, full masks.
        send_word(WORD_ONES, $urandom(), WORD_ONES, POS_FIRST);

        // Every raster operation once, with the skew climbing to its top,
        // the walk direction alternating and the row position cycling.
        for (int r = 0; r < 16; r++)
        begin
            settle();
            write_config(rop_t'(r), (r == 0) ? skew_t'(0) : skew_t'(2 * r + 1), r[0],
                         $urandom(), $urandom());
            send_word(r[1] ? WORD_ONES : $urandom(), r[2] ? '0 : $urandom(),
                      r[3] ? WORD_ONES : $urandom(), position_t'(r % 3 + 1));
        end

        // A primed first word merges with the carried source word; the next
        // first word is no longer primed and clears the merge-mask bits.
        settle();
        write_config(ROP_S, skew_t'(8), 1'b0, WORD_ONES, WORD_ONES);
        send_word($urandom(), $urandom(), WORD_ONES, POS_PRIME);
        send_word($urandom(), $urandom(), WORD_ONES, POS_FIRST);
        send_word($urandom(), $urandom(), WORD_ONES, POS_FIRST);

        // With zero skew walked backward the merge mask is all ones, so a
        // middle word without a first word takes the carried word whole.
        settle();
        write_config(ROP_S_XOR_D, '0, 1'b1, $urandom(), $urandom());
        send_word($urandom(), $urandom(), $urandom(), POS_MIDDLE);
        send_word($urandom(), $urandom(), WORD_ONES, POS_LAST);

        // Random phases: fresh settings each time, then mostly whole rows
        // with the odd stray word of any position in between.
        random_start = words_sent;
        while (words_sent - random_start < RANDOM_WORDS)
        begin
            settle();
            write_config(rop_t'($urandom_range(0, 15)), rand_skew(),
                         1'($urandom_range(0, 1)), rand_mask(), rand_mask());
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS &&
                   words_sent - random_start < RANDOM_WORDS)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_word(rand_word(), rand_word(), rand_texture(),
                              position_t'($urandom_range(0, 3)));
                else
                    send_row();
            end
        end

        settle();
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
